>>> hdl/btms_pkg.sv
`timescale 1ns / 1ps

package btms_pkg;

    // Samples kept per channel
    localparam int DEPTH = 1024;
    localparam int NCHAN = 3;

    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ADDR_W = $clog2(NCHAN * DEPTH);

    // One sample in milliseconds fits 20 bits even for digits out of range
    localparam int VAL_W  = 20;
    localparam int SUM_W  = VAL_W + CNT_W;
    localparam int SQ_W   = 50;
    localparam int ROOT_W = (SQ_W + 1) / 2;
    localparam int D_W    = (SUM_W > ROOT_W) ? SUM_W : ROOT_W + 1;
    localparam int CMP_W  = D_W + 1;

    localparam logic [SQ_W-1:0] SQ_CAP = {SQ_W{1'b1}};

    localparam int MIN_W    = 4;
    localparam int REST_W   = 16;
    localparam int OCNT_W   = 11;
    localparam int MS_MIN   = 60000;
    localparam int MS_SEC   = 1000;
    localparam int MIN_MAX  = 15;
    localparam int REST_MAX = 65535;

    localparam logic [1:0] CH_SYSTEM = 2'd2;

    typedef struct packed {
        logic [1:0] channel;
        logic [3:0] minutes;
        logic [3:0] whole_seconds;
        logic [9:0] millis;
        logic       batch_end;
    } sample_t;

    typedef struct packed {
        logic [1:0]        out_channel;
        logic [OCNT_W-1:0] runs;
        logic [MIN_W-1:0]  mean_minutes;
        logic [REST_W-1:0] mean_rest_ms;
        logic [MIN_W-1:0]  dev_minutes;
        logic [REST_W-1:0] dev_rest_ms;
        logic [OCNT_W-1:0] inside_count;
        logic              final_result;
    } result_t;

endpackage

>>> hdl/btms_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle
module btms_div
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [btms_pkg::SQ_W-1:0]        dividend,
    input  logic [btms_pkg::CNT_W-1:0]       divisor,
    output logic                             done,
    output logic [btms_pkg::SQ_W-1:0]        quotient
);

    localparam int STEP_W = $clog2(btms_pkg::SQ_W + 1);

    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [STEP_W-1:0]              step_reg, step_next;
    logic [btms_pkg::CNT_W-1:0]     rem_reg, rem_next;
    logic [btms_pkg::CNT_W-1:0]     dsr_reg, dsr_next;
    logic [btms_pkg::SQ_W-1:0]      quo_reg, quo_next;
    logic [btms_pkg::CNT_W:0]       trial;

    // Shift one dividend bit into the remainder and try a subtract
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        quo_next  = quo_reg;
        trial     = {rem_reg, quo_reg[btms_pkg::SQ_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            dsr_next  = divisor;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = btms_pkg::CNT_W'(trial - {1'b0, dsr_reg});
                quo_next = {quo_reg[btms_pkg::SQ_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[btms_pkg::CNT_W-1:0];
                quo_next = {quo_reg[btms_pkg::SQ_W-2:0], 1'b0};
            end
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(btms_pkg::SQ_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
        quo_reg  <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> hdl/btms_isqrt.sv
`timescale 1ns / 1ps

// Floor integer square root, one result bit per cycle
module btms_isqrt
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [btms_pkg::SQ_W-1:0]     value,
    output logic                          done,
    output logic [btms_pkg::ROOT_W-1:0]   root
);

    localparam int STEP_W = $clog2(btms_pkg::ROOT_W + 1);
    localparam int RES_W  = btms_pkg::SQ_W + 1;

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [STEP_W-1:0]             step_reg, step_next;
    logic [btms_pkg::SQ_W-1:0]     v_reg, v_next;
    logic [RES_W-1:0]              res_reg, res_next;
    logic [RES_W-1:0]              bit_reg, bit_next;
    logic [RES_W-1:0]              trial;

    // Test the next pair of bits against the partial root
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        v_next    = v_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        trial     = res_reg + bit_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            v_next    = value;
            res_next  = '0;
            bit_next  = RES_W'(1) << (2 * (btms_pkg::ROOT_W - 1));
        end
        else if (busy_reg)
        begin
            if ({1'b0, v_reg} >= trial)
            begin
                v_next   = btms_pkg::SQ_W'({1'b0, v_reg} - trial);
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next  = bit_reg >> 2;
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(btms_pkg::ROOT_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        v_reg    <= v_next;
        res_reg  <= res_next;
        bit_reg  <= bit_next;
    end

    assign done = done_reg;
    assign root = res_reg[btms_pkg::ROOT_W-1:0];

endmodule

>>> hdl/batch_time_mean_stddev.sv
`timescale 1ns / 1ps
// Loading: one sample request per cycle while idle, written to the sample RAM (one write port).
// End of batch, per channel: mean divide, squared-deviation pass, variance divide,
// square root, counting pass and minute split (straight to the split when runs is zero);
// loading resumes after the third result is registered.
// Reset clears counts, sums and control; the sample RAM holds no reset value.
module batch_time_mean_stddev
(
    input  logic                clk,
    input  logic                rst_n,
    input  btms_pkg::sample_t   sample,
    input  logic                sample_valid,
    output logic                sample_ready,
    output btms_pkg::result_t   result,
    output logic                result_valid,
    input  logic                result_ready
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_MDIV  = 8'b0000_0010,
        S_SQ    = 8'b0000_0100,
        S_VDIV  = 8'b0000_1000,
        S_SQRT  = 8'b0001_0000,
        S_CNT   = 8'b0010_0000,
        S_SPLIT = 8'b0100_0000,
        S_EMIT  = 8'b1000_0000
    } state_t;

    localparam int CNT_W  = btms_pkg::CNT_W;
    localparam int SUM_W  = btms_pkg::SUM_W;
    localparam int SQ_W   = btms_pkg::SQ_W;
    localparam int ROOT_W = btms_pkg::ROOT_W;
    localparam int D_W    = btms_pkg::D_W;
    localparam int CMP_W  = btms_pkg::CMP_W;
    localparam int VAL_W  = btms_pkg::VAL_W;
    localparam int MIN_W  = btms_pkg::MIN_W;

    state_t                     state_reg, state_next;
    logic [1:0]                 chan_reg, chan_next;
    logic                       go_reg, go_next;
    logic [CNT_W-1:0]           counts_reg [btms_pkg::NCHAN];
    logic [CNT_W-1:0]           counts_next [btms_pkg::NCHAN];
    logic [SUM_W-1:0]           sums_reg [btms_pkg::NCHAN];
    logic [SUM_W-1:0]           sums_next [btms_pkg::NCHAN];
    logic [SUM_W-1:0]           mean_reg, mean_next;
    logic [ROOT_W-1:0]          dev_reg, dev_next;
    logic [SQ_W-1:0]            acc_reg, acc_next;
    logic [CNT_W-1:0]           inside_reg, inside_next;
    logic [CNT_W-1:0]           iss_reg, iss_next;
    logic                       v1_reg, v1_next;
    logic                       v2_reg, v3_reg;
    logic [D_W-1:0]             d_reg;
    logic [SQ_W-1:0]            sqv_reg;
    logic [VAL_W-1:0]           rd_data_reg;
    logic [MIN_W-1:0]           mm_reg, mm_next, dm_reg, dm_next;
    logic [SUM_W-1:0]           mr_reg, mr_next;
    logic [ROOT_W-1:0]          dr_reg, dr_next;
    logic                       out_valid_reg, out_valid_next;
    btms_pkg::result_t          out_reg, out_next;

    logic [VAL_W-1:0]           mem [btms_pkg::NCHAN * btms_pkg::DEPTH];
    logic                       wr_en, rd_en;
    logic [btms_pkg::ADDR_W-1:0] wr_addr, rd_addr;
    logic [VAL_W-1:0]           ms;

    logic                       div_start, div_done, sqrt_start, sqrt_done;
    logic [SQ_W-1:0]            div_dividend, div_quotient;
    logic [ROOT_W-1:0]          sqrt_root;

    logic [CNT_W-1:0]           runs, n;
    logic                       in_acc, pass_done;
    logic [D_W-1:0]             x_ext, mean_ext, d_val;
    logic [CMP_W-1:0]           x_cmp, mean_cmp, dev_cmp;
    logic                       inside_hit;
    logic                       mr_step, dr_step;
    logic [SQ_W:0]              acc_sum;

    assign runs   = counts_reg[btms_pkg::CH_SYSTEM];
    assign n      = counts_reg[chan_reg];
    assign in_acc = sample_valid && sample_ready;

    // Sample in whole milliseconds
    assign ms = VAL_W'(sample.minutes) * VAL_W'(btms_pkg::MS_MIN)
              + VAL_W'(sample.whole_seconds) * VAL_W'(btms_pkg::MS_SEC)
              + VAL_W'(sample.millis);

    assign wr_en   = in_acc && (sample.channel < 2'(btms_pkg::NCHAN))
                   && (counts_reg[sample.channel] < CNT_W'(btms_pkg::DEPTH));
    assign wr_addr = btms_pkg::ADDR_W'(sample.channel * btms_pkg::DEPTH)
                   + btms_pkg::ADDR_W'(counts_reg[sample.channel][btms_pkg::IDX_W-1:0]);
    assign rd_en   = ((state_reg == S_SQ) || (state_reg == S_CNT)) && (iss_reg < n);
    assign rd_addr = btms_pkg::ADDR_W'(chan_reg * btms_pkg::DEPTH)
                   + btms_pkg::ADDR_W'(iss_reg[btms_pkg::IDX_W-1:0]);

    // Sample RAM, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= ms;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Shared divider for mean and variance
    assign div_dividend = (state_reg == S_MDIV) ? SQ_W'(sums_reg[chan_reg]) : acc_reg;

    btms_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (runs),
        .done     (div_done),
        .quotient (div_quotient)
    );

    btms_isqrt u_isqrt
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .value (div_quotient),
        .done  (sqrt_done),
        .root  (sqrt_root)
    );

    // Deviation and window test on the word read back
    assign x_ext    = D_W'(rd_data_reg);
    assign mean_ext = D_W'(mean_reg);
    assign d_val    = (x_ext > mean_ext) ? (x_ext - mean_ext) : (mean_ext - x_ext);
    assign x_cmp    = CMP_W'(rd_data_reg);
    assign mean_cmp = CMP_W'(mean_reg);
    assign dev_cmp  = CMP_W'(dev_reg);
    assign inside_hit = ((x_cmp + dev_cmp) > mean_cmp) && (x_cmp < (mean_cmp + dev_cmp));

    // Square and saturate
    always_ff @(posedge clk)
    begin
        d_reg <= d_val;
        if (d_reg[D_W-1:ROOT_W] != '0)
        begin
            sqv_reg <= btms_pkg::SQ_CAP;
        end
        else
        begin
            sqv_reg <= SQ_W'(d_reg[ROOT_W-1:0] * d_reg[ROOT_W-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= v1_reg && (state_reg == S_SQ);
            v3_reg <= v2_reg;
        end
    end

    assign acc_sum   = {1'b0, acc_reg} + {1'b0, sqv_reg};
    assign pass_done = (iss_reg == n) && !v1_reg && !v2_reg && !v3_reg;
    assign mr_step   = (mm_reg < MIN_W'(btms_pkg::MIN_MAX))
                     && (mr_reg >= SUM_W'(btms_pkg::MS_MIN));
    assign dr_step   = (dm_reg < MIN_W'(btms_pkg::MIN_MAX))
                     && (dr_reg >= ROOT_W'(btms_pkg::MS_MIN));
    assign sample_ready = (state_reg == S_IDLE);

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        chan_next      = chan_reg;
        go_next        = go_reg;
        counts_next    = counts_reg;
        sums_next      = sums_reg;
        mean_next      = mean_reg;
        dev_next       = dev_reg;
        acc_next       = acc_reg;
        inside_next    = inside_reg;
        iss_next       = iss_reg;
        v1_next        = rd_en;
        mm_next        = mm_reg;
        mr_next        = mr_reg;
        dm_next        = dm_reg;
        dr_next        = dr_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        div_start      = 1'b0;
        sqrt_start     = 1'b0;

        // Drop the result once taken
        if (out_valid_reg && result_ready)
        begin
            out_valid_next = 1'b0;
        end

        // Advance the read index during a pass
        if (rd_en)
        begin
            iss_next = iss_reg + 1'b1;
        end
        if (v3_reg)
        begin
            acc_next = acc_sum[SQ_W] ? btms_pkg::SQ_CAP : acc_sum[SQ_W-1:0];
        end
        if (v1_reg && (state_reg == S_CNT) && inside_hit)
        begin
            inside_next = inside_reg + 1'b1;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (wr_en)
                begin
                    counts_next[sample.channel] = counts_reg[sample.channel] + 1'b1;
                    sums_next[sample.channel]   = sums_reg[sample.channel] + SUM_W'(ms);
                end
                if (in_acc && sample.batch_end)
                begin
                    chan_next  = '0;
                    go_next    = 1'b0;
                    state_next = S_MDIV;
                end
            end
            S_MDIV:
            begin
                if (runs == '0)
                begin
                    inside_next = '0;
                    mm_next     = '0;
                    mr_next     = '0;
                    dm_next     = '0;
                    dr_next     = '0;
                    state_next  = S_SPLIT;
                end
                else if (!go_reg)
                begin
                    div_start = 1'b1;
                    go_next   = 1'b1;
                end
                else if (div_done)
                begin
                    mean_next  = div_quotient[SUM_W-1:0];
                    go_next    = 1'b0;
                    acc_next   = '0;
                    iss_next   = '0;
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                if (pass_done)
                begin
                    state_next = S_VDIV;
                end
            end
            S_VDIV:
            begin
                if (!go_reg)
                begin
                    div_start = 1'b1;
                    go_next   = 1'b1;
                end
                else if (div_done)
                begin
                    sqrt_start = 1'b1;
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                if (sqrt_done)
                begin
                    dev_next    = sqrt_root;
                    go_next     = 1'b0;
                    iss_next    = '0;
                    inside_next = '0;
                    state_next  = S_CNT;
                end
            end
            S_CNT:
            begin
                if (pass_done)
                begin
                    mm_next    = '0;
                    mr_next    = mean_reg;
                    dm_next    = '0;
                    dr_next    = dev_reg;
                    state_next = S_SPLIT;
                end
            end
            S_SPLIT:
            begin
                if (mr_step)
                begin
                    mr_next = mr_reg - SUM_W'(btms_pkg::MS_MIN);
                    mm_next = mm_reg + 1'b1;
                end
                if (dr_step)
                begin
                    dr_next = dr_reg - ROOT_W'(btms_pkg::MS_MIN);
                    dm_next = dm_reg + 1'b1;
                end
                if (!mr_step && !dr_step)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    out_valid_next        = 1'b1;
                    out_next.out_channel  = chan_reg;
                    out_next.runs         = btms_pkg::OCNT_W'(runs);
                    out_next.mean_minutes = mm_reg;
                    out_next.mean_rest_ms = (mr_reg > SUM_W'(btms_pkg::REST_MAX))
                                          ? btms_pkg::REST_W'(btms_pkg::REST_MAX)
                                          : mr_reg[btms_pkg::REST_W-1:0];
                    out_next.dev_minutes  = dm_reg;
                    out_next.dev_rest_ms  = (dr_reg > ROOT_W'(btms_pkg::REST_MAX))
                                          ? btms_pkg::REST_W'(btms_pkg::REST_MAX)
                                          : dr_reg[btms_pkg::REST_W-1:0];
                    out_next.inside_count = btms_pkg::OCNT_W'(inside_reg);
                    out_next.final_result = (chan_reg == btms_pkg::CH_SYSTEM);
                    if (chan_reg == btms_pkg::CH_SYSTEM)
                    begin
                        for (int c = 0; c < btms_pkg::NCHAN; c++)
                        begin
                            counts_next[c] = '0;
                            sums_next[c]   = '0;
                        end
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        chan_next  = chan_reg + 1'b1;
                        go_next    = 1'b0;
                        state_next = S_MDIV;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            chan_reg      <= '0;
            go_reg        <= 1'b0;
            v1_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int c = 0; c < btms_pkg::NCHAN; c++)
            begin
                counts_reg[c] <= '0;
                sums_reg[c]   <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            chan_reg      <= chan_next;
            go_reg        <= go_next;
            v1_reg        <= v1_next;
            out_valid_reg <= out_valid_next;
            counts_reg    <= counts_next;
            sums_reg      <= sums_next;
        end
    end

    // Working values and result payload
    always_ff @(posedge clk)
    begin
        mean_reg   <= mean_next;
        dev_reg    <= dev_next;
        acc_reg    <= acc_next;
        inside_reg <= inside_next;
        iss_reg    <= iss_next;
        mm_reg     <= mm_next;
        mr_reg     <= mr_next;
        dm_reg     <= dm_next;
        dr_reg     <= dr_next;
        out_reg    <= out_next;
    end

    assign result       = out_reg;
    assign result_valid = out_valid_reg;

endmodule
